// ===== rtl/core/sncp_pkg.sv =====
package sncp_pkg;

    // Fixed-point fraction bits used by default
    localparam int COORD_FRAC_BITS_DEF = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_FOCAL_X    = 3'd0,
        REG_FOCAL_Y    = 3'd1,
        REG_CENTER_X   = 3'd2,
        REG_CENTER_Y   = 3'd3,
        REG_NEAR_PLANE = 3'd4
    } reg_idx_t;

    localparam logic [31:0] FOCAL_X_RESET  = 32'd33554432;
    localparam logic [31:0] FOCAL_Y_RESET  = 32'd33554432;
    localparam logic [31:0] CENTER_X_RESET = 32'd20971520;
    localparam logic [31:0] CENTER_Y_RESET = 32'd15728640;

    // Divider geometry: clip offset and projection quotient
    localparam int CLIP_QW = 32;
    localparam int CLIP_DW = 32;
    localparam int PROJ_QW = 57;
    localparam int PROJ_DW = 32;
    localparam logic [PROJ_QW-1:0] QUOT_LIMIT = PROJ_QW'(1) << (PROJ_QW - 1);

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic [1:0]         axis_tag;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] pixel_u0;
        logic signed [15:0] pixel_v0;
        logic signed [15:0] pixel_u1;
        logic signed [15:0] pixel_v1;
        logic [1:0]         axis_out;
        logic               was_clipped;
    } out_item_t;

endpackage

// ===== rtl/core/segment_near_clip_project.sv =====
// Channel   Direction  Handshake         Payload
// s_        in         s_valid/s_ready   sncp_pkg::in_item_t   (one segment)
// m_        out        m_valid/m_ready   sncp_pkg::out_item_t  (zero or one per segment)
// apb       in         psel/penable      focal, center, near registers
//
// One segment per cycle while no result waits untaken; the pipeline holds the 32-stage clip
// divider and the 57-stage projection dividers plus nine datapath stages.
// Segments fully behind the near plane leave no result.
// Synchronous active-low reset clears valid bits and restores the registers.
// A result held on m_ with m_ready low stalls the whole pipeline in place.
module segment_near_clip_project #(
    parameter int COORD_FRAC_BITS = sncp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sncp_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sncp_pkg::out_item_t                 m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sncp_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [sncp_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [sncp_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import sncp_pkg::*;

    localparam longint unsigned NEAR_RESET_L =
        ((64'd1 << COORD_FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic [30:0] NEAR_RESET = NEAR_RESET_L[30:0];
    localparam int VLEN = 9 + CLIP_QW + PROJ_QW;
    localparam int PAD_W = PROJ_QW + PROJ_DW - 64;

    typedef struct packed {
        logic [1:0]         axis;
        logic               clip_a;
        logic               clip_b;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic               sdx;
    } clip_side_t;

    typedef struct packed {
        logic [1:0] axis;
        logic       clipped;
    } tag_t;

    typedef struct packed {
        logic ovf;
        logic nmz;
        logic neg;
    } proj_flag_t;

    // Configuration registers
    logic [31:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [30:0] near_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg  <= FOCAL_X_RESET;
            focal_y_reg  <= FOCAL_Y_RESET;
            center_x_reg <= CENTER_X_RESET;
            center_y_reg <= CENTER_Y_RESET;
            near_reg     <= NEAR_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
                REG_FOCAL_X:    focal_x_reg  <= pwdata;
                REG_FOCAL_Y:    focal_y_reg  <= pwdata;
                REG_CENTER_X:   center_x_reg <= pwdata;
                REG_CENTER_Y:   center_y_reg <= pwdata;
                REG_NEAR_PLANE: near_reg     <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
            REG_FOCAL_X:    prdata = focal_x_reg;
            REG_FOCAL_Y:    prdata = focal_y_reg;
            REG_CENTER_X:   prdata = center_x_reg;
            REG_CENTER_Y:   prdata = center_y_reg;
            REG_NEAR_PLANE: prdata = {1'b0, near_reg};
            default:        prdata = '0;
        endcase
    end

    // Global advance: the pipe moves unless a result waits untaken
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Valid bits for every stage
    logic [VLEN-1:0] valid_line_reg, valid_line_next;
    logic            drop;

    always_comb begin
        valid_line_next    = {valid_line_reg[VLEN-2:0], s_valid};
        valid_line_next[1] = valid_line_reg[0] && !drop;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_line_reg <= '0;
        end else if (en) begin
            valid_line_reg <= valid_line_next;
        end
    end

    assign m_valid = valid_line_reg[VLEN-1];

    // Stage 0: input register
    in_item_t s0_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            s0_reg <= s_data;
        end
    end

    // Stage 1: plane tests, pick behind and front endpoint, offsets
    logic signed [32:0] near_s, az_s, bz_s, px_s, py_s, pz_s, qx_s, qy_s, qz_s;
    logic signed [32:0] dz_num, dz_den, dx, dy, ndx, ndy;
    logic a_behind, b_behind, a_front, b_front, clip_a, clip_b;
    clip_side_t  s1_side_next;

    always_comb begin
        near_s   = {2'b00, near_reg};
        az_s     = {s0_reg.a_z[31], s0_reg.a_z};
        bz_s     = {s0_reg.b_z[31], s0_reg.b_z};
        a_behind = az_s < near_s;
        b_behind = bz_s < near_s;
        a_front  = az_s > near_s;
        b_front  = bz_s > near_s;
        clip_a   = a_behind && b_front;
        clip_b   = b_behind && a_front;
        drop     = a_behind && b_behind;
        if (clip_a) begin
            px_s = {s0_reg.a_x[31], s0_reg.a_x};
            py_s = {s0_reg.a_y[31], s0_reg.a_y};
            pz_s = az_s;
            qx_s = {s0_reg.b_x[31], s0_reg.b_x};
            qy_s = {s0_reg.b_y[31], s0_reg.b_y};
            qz_s = bz_s;
        end else begin
            px_s = {s0_reg.b_x[31], s0_reg.b_x};
            py_s = {s0_reg.b_y[31], s0_reg.b_y};
            pz_s = bz_s;
            qx_s = {s0_reg.a_x[31], s0_reg.a_x};
            qy_s = {s0_reg.a_y[31], s0_reg.a_y};
            qz_s = az_s;
        end
        dz_num = qz_s - near_s;
        dz_den = qz_s - pz_s;
        dx     = px_s - qx_s;
        dy     = py_s - qy_s;
        ndx    = -dx;
        ndy    = -dy;

        s1_side_next.axis   = s0_reg.axis_tag;
        s1_side_next.clip_a = clip_a;
        s1_side_next.clip_b = clip_b;
        s1_side_next.ax     = s0_reg.a_x;
        s1_side_next.ay     = s0_reg.a_y;
        s1_side_next.az     = s0_reg.a_z;
        s1_side_next.bx     = s0_reg.b_x;
        s1_side_next.by     = s0_reg.b_y;
        s1_side_next.bz     = s0_reg.b_z;
        s1_side_next.sdx    = dx[32];
    end

    clip_side_t  s1_side_reg;
    logic        s1_sdy_reg;
    logic [31:0] s1_magx_reg, s1_magy_reg, s1_num_reg, s1_den_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_side_reg <= s1_side_next;
            s1_sdy_reg  <= dy[32];
            s1_magx_reg <= dx[32] ? ndx[31:0] : dx[31:0];
            s1_magy_reg <= dy[32] ? ndy[31:0] : dy[31:0];
            s1_num_reg  <= (clip_a || clip_b) ? dz_num[31:0] : 32'd0;
            s1_den_reg  <= (clip_a || clip_b) ? dz_den[31:0] : 32'd1;
        end
    end

    // Stage 2: offset times front depth margin
    clip_side_t  s2_side_reg;
    logic        s2_sdy_reg;
    logic [63:0] s2_prodx_reg, s2_prody_reg;
    logic [31:0] s2_den_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_side_reg  <= s1_side_reg;
            s2_sdy_reg   <= s1_sdy_reg;
            s2_prodx_reg <= {32'd0, s1_magx_reg} * {32'd0, s1_num_reg};
            s2_prody_reg <= {32'd0, s1_magy_reg} * {32'd0, s1_num_reg};
            s2_den_reg   <= s1_den_reg;
        end
    end

    // Clip dividers: offset scaled by margin over depth span
    logic [CLIP_QW-1:0]        rx, ry;
    logic [$bits(clip_side_t)-1:0] cd_side_out;
    logic                      cd_sdy_out;
    clip_side_t                cd_side;

    sncp_div_pipe #(
        .QW(CLIP_QW), .DW(CLIP_DW), .SIDE_W($bits(clip_side_t))
    ) u_clip_div_x (
        .aclk(aclk), .en(en),
        .dividend(s2_prodx_reg), .divisor(s2_den_reg),
        .side_in(s2_side_reg), .quotient(rx), .side_out(cd_side_out)
    );

    sncp_div_pipe #(
        .QW(CLIP_QW), .DW(CLIP_DW), .SIDE_W(1)
    ) u_clip_div_y (
        .aclk(aclk), .en(en),
        .dividend(s2_prody_reg), .divisor(s2_den_reg),
        .side_in(s2_sdy_reg), .quotient(ry), .side_out(cd_sdy_out)
    );

    assign cd_side = clip_side_t'(cd_side_out);

    // Stage 3: moved endpoint and final coordinates
    logic signed [32:0] qx3, qy3, newx, newy;
    logic signed [31:0] s3_coord_reg [4];
    logic signed [31:0] s3_z_reg [2];
    tag_t               s3_tag_reg;

    always_comb begin
        qx3  = cd_side.clip_a ? {cd_side.bx[31], cd_side.bx} : {cd_side.ax[31], cd_side.ax};
        qy3  = cd_side.clip_a ? {cd_side.by[31], cd_side.by} : {cd_side.ay[31], cd_side.ay};
        newx = cd_side.sdx ? qx3 - $signed({1'b0, rx}) : qx3 + $signed({1'b0, rx});
        newy = cd_sdy_out  ? qy3 - $signed({1'b0, ry}) : qy3 + $signed({1'b0, ry});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_coord_reg[0] <= cd_side.clip_a ? newx[31:0] : cd_side.ax;
            s3_coord_reg[1] <= cd_side.clip_a ? newy[31:0] : cd_side.ay;
            s3_coord_reg[2] <= cd_side.clip_b ? newx[31:0] : cd_side.bx;
            s3_coord_reg[3] <= cd_side.clip_b ? newy[31:0] : cd_side.by;
            s3_z_reg[0]     <= cd_side.clip_a ? {1'b0, near_reg} : cd_side.az;
            s3_z_reg[1]     <= cd_side.clip_b ? {1'b0, near_reg} : cd_side.bz;
            s3_tag_reg      <= '{axis: cd_side.axis,
                                 clipped: cd_side.clip_a || cd_side.clip_b};
        end
    end

    // Tag delay through stages 4 and 5, the projection dividers, and stages 6 and 7
    tag_t s4_tag_reg, s5_tag_reg, s6_tag_reg, s7_tag_reg;
    tag_t tag_line_reg [PROJ_QW];

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_tag_reg      <= s3_tag_reg;
            s5_tag_reg      <= s4_tag_reg;
            tag_line_reg[0] <= s5_tag_reg;
            for (int i = 1; i < PROJ_QW; i++) begin
                tag_line_reg[i] <= tag_line_reg[i-1];
            end
            s6_tag_reg      <= tag_line_reg[PROJ_QW-1];
            s7_tag_reg      <= s6_tag_reg;
        end
    end

    // Projection lanes: u0, v0, u1, v1
    logic signed [15:0] pix [4];

    for (genvar g = 0; g < 4; g++) begin : g_lane
        logic [31:0]         f_sel, c_sel;
        logic signed [31:0]  coord, z;
        logic signed [31:0]  ncoord, nz;
        logic [31:0]         s4_mc_reg, s4_mz_reg, s5_mz_reg;
        logic                s4_neg_reg, s5_neg_reg;
        logic [63:0]         s5_nm_reg;
        proj_flag_t          flag_in;
        logic [2:0]          flag_out_bits;
        proj_flag_t          flag_out;
        logic [PROJ_QW-1:0]  quot, qmag;
        logic signed [57:0]  s6_q_reg, s7_t_reg, tmag;
        logic [56:0]         tm;

        assign f_sel = (g % 2 == 0) ? focal_x_reg : focal_y_reg;
        assign c_sel = (g % 2 == 0) ? center_x_reg : center_y_reg;

        // Stage 4: magnitudes and quotient sign
        assign coord  = s3_coord_reg[g];
        assign z      = s3_z_reg[g / 2];
        assign ncoord = -coord;
        assign nz     = -z;

        always_ff @(posedge aclk) begin
            if (en) begin
                s4_mc_reg  <= coord[31] ? ncoord : coord;
                s4_mz_reg  <= z[31] ? nz : z;
                s4_neg_reg <= coord[31] ^ z[31];
            end
        end

        // Stage 5: focal times coordinate
        always_ff @(posedge aclk) begin
            if (en) begin
                s5_nm_reg  <= {32'd0, f_sel} * {32'd0, s4_mc_reg};
                s5_mz_reg  <= s4_mz_reg;
                s5_neg_reg <= s4_neg_reg;
            end
        end

        // Quotient past the limit (zero depth included, unless the product is zero) saturates
        assign flag_in.ovf = PROJ_DW'(s5_nm_reg[63:PROJ_QW]) >= s5_mz_reg;
        assign flag_in.nmz = s5_nm_reg == 64'd0;
        assign flag_in.neg = s5_neg_reg;

        sncp_div_pipe #(
            .QW(PROJ_QW), .DW(PROJ_DW), .SIDE_W(3)
        ) u_proj_div (
            .aclk(aclk), .en(en),
            .dividend({PAD_W'(0), s5_nm_reg}), .divisor(s5_mz_reg),
            .side_in(flag_in), .quotient(quot), .side_out(flag_out_bits)
        );

        assign flag_out = proj_flag_t'(flag_out_bits);

        // Stage 6: clamp and apply sign
        always_comb begin
            if (flag_out.nmz) begin
                qmag = '0;
            end else if (flag_out.ovf || quot > QUOT_LIMIT) begin
                qmag = QUOT_LIMIT;
            end else begin
                qmag = quot;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s6_q_reg <= flag_out.neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
            end
        end

        // Stage 7: add principal point
        always_ff @(posedge aclk) begin
            if (en) begin
                s7_t_reg <= s6_q_reg + $signed({26'd0, c_sel});
            end
        end

        // Truncate toward zero and saturate to 16 bits
        assign tmag = s7_t_reg[57] ? -s7_t_reg : s7_t_reg;
        assign tm   = tmag[56:0] >> COORD_FRAC_BITS;

        always_comb begin
            if (!s7_t_reg[57]) begin
                pix[g] = (tm > 57'd32767) ? 16'sd32767 : $signed(tm[15:0]);
            end else begin
                pix[g] = (tm > 57'd32768) ? -16'sd32768 : -$signed(tm[15:0]);
            end
        end
    end

    // Output register
    out_item_t m_data_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.pixel_u0    <= pix[0];
            m_data_reg.pixel_v0    <= pix[1];
            m_data_reg.pixel_u1    <= pix[2];
            m_data_reg.pixel_v1    <= pix[3];
            m_data_reg.axis_out    <= s7_tag_reg.axis;
            m_data_reg.was_clipped <= s7_tag_reg.clipped;
        end
    end

    assign m_data = m_data_reg;

endmodule

// ===== rtl/core/sncp_div_pipe.sv =====
module sncp_div_pipe #(
    parameter int QW     = 32,
    parameter int DW     = 32,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [QW+DW-1:0]  dividend,
    input  logic [DW-1:0]     divisor,
    input  logic [SIDE_W-1:0] side_in,
    output logic [QW-1:0]     quotient,
    output logic [SIDE_W-1:0] side_out
);
    // Restoring divider, one quotient bit per stage.
    // The upper DW bits of the dividend must be below the divisor.
    logic [DW-1:0]     rem_reg  [QW];
    logic [QW-1:0]     low_reg  [QW];
    logic [DW-1:0]     dv_reg   [QW];
    logic [SIDE_W-1:0] side_reg [QW];

    logic [DW-1:0]     rem_next  [QW];
    logic [QW-1:0]     low_next  [QW];
    logic [DW-1:0]     dv_next   [QW];
    logic [SIDE_W-1:0] side_next [QW];

    always_comb begin
        logic [DW-1:0]     rem_src;
        logic [QW-1:0]     low_src;
        logic [DW:0]       shifted;
        logic              fits;
        for (int i = 0; i < QW; i++) begin
            if (i == 0) begin
                rem_src      = dividend[QW+DW-1:QW];
                low_src      = dividend[QW-1:0];
                dv_next[i]   = divisor;
                side_next[i] = side_in;
            end else begin
                rem_src      = rem_reg[i-1];
                low_src      = low_reg[i-1];
                dv_next[i]   = dv_reg[i-1];
                side_next[i] = side_reg[i-1];
            end
            shifted     = {rem_src, low_src[QW-1]};
            fits        = shifted >= {1'b0, dv_next[i]};
            rem_next[i] = fits ? DW'(shifted - {1'b0, dv_next[i]}) : shifted[DW-1:0];
            low_next[i] = {low_src[QW-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < QW; i++) begin
                rem_reg[i]  <= rem_next[i];
                low_reg[i]  <= low_next[i];
                dv_reg[i]   <= dv_next[i];
                side_reg[i] <= side_next[i];
            end
        end
    end

    assign quotient = low_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

// ===== rtl/core/sncp_checker.sv =====
module sncp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input sncp_pkg::out_item_t             m_data,
    input logic                            pready
);
    import sncp_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // An offered segment stays offered until its transfer
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input valid dropped before transfer");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Input side only stalls behind a waiting result
    a_ready_free: assert property (@(posedge aclk)
        !m_valid || m_ready |-> s_ready)
        else $error("input stalled with free output");

    // Register port never inserts wait states
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind segment_near_clip_project sncp_checker u_sncp_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data(m_data),
    .pready(pready)
);
